// ===== sv/mftt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_pkg
// shared types, constants and helpers of the motor feedback turn tracker
// ----------------------------------------------------------------------------
package mftt_pkg;

  // default sizing
  localparam int SLOT_COUNT_DEF      = 32;
  localparam int COUNTS_PER_TURN_DEF = 8192;

  // widest slot index over the supported slot counts (up to 64)
  localparam int SLOT_IDX_W = 6;

  // register reset values and widths
  localparam int BASE_ID_W  = 11;
  localparam int OFFSET_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam logic [BASE_ID_W-1:0] BASE_ID_RST = 11'd513;
  localparam logic [OFFSET_W-1:0]  OFFSET_RST  = 5'd11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 1'd1;

  // stream widths
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 96;
  localparam int M_TUSER_W = 4;

  // wrap detection thresholds
  localparam logic [15:0] WRAP_MID  = 16'd5000;
  localparam logic [15:0] WRAP_LOW  = 16'd4000;
  localparam logic [15:0] WRAP_HIGH = 16'd6000;

  // result codes
  typedef enum logic [3:0] {
    ST_UPDATED  = 4'd0,
    ST_ROUTED_0 = 4'd1,
    ST_ROUTED_1 = 4'd2,
    ST_ROUTED_2 = 4'd3,
    ST_ROUTED_3 = 4'd4,
    ST_ROUTED_4 = 4'd5,
    ST_ROUTED_5 = 4'd6,
    ST_BAD_SLOT = 4'd7,
    ST_CLEARED  = 4'd8
  } status_t;

  // identifiers handled elsewhere, in routing code order
  localparam logic [10:0] ROUTED_IDS [6] = '{11'h307, 11'h008, 11'h301,
                                            11'h302, 11'h303, 11'h304};
  localparam status_t ROUTED_CODES [6] = '{ST_ROUTED_0, ST_ROUTED_1, ST_ROUTED_2,
                                          ST_ROUTED_3, ST_ROUTED_4, ST_ROUTED_5};

  typedef enum logic [1:0] {
    K_UPDATE,
    K_CLEAR,
    K_REPORT
  } kind_t;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } fsm_state_t;

  // one decoded item
  typedef struct packed {
    kind_t                 kind;
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [15:0]           angle;
    logic [15:0]           speed;
    logic [15:0]           current;
    logic [7:0]            temp;
  } dec_t;

  // one slot entry of the state memory
  typedef struct packed {
    logic [31:0] count;
    logic [15:0] angle;
  } state_word_t;

  // routing code lookup, gives ST_UPDATED for a motor identifier
  function automatic status_t routed_code(input logic [10:0] id);
    status_t code;
    code = ST_UPDATED;
    for (int i = 0; i < 6; i++) begin
      if (id == ROUTED_IDS[i]) begin
        code = ROUTED_CODES[i];
      end
    end
    return code;
  endfunction

endpackage

// ===== sv/mftt_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_decode
// classifies an incoming item and maps its identifier to a motor slot
// ----------------------------------------------------------------------------
module mftt_decode import mftt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                 mode,
  input  logic                 bus_select,
  input  logic [10:0]          frame_identifier,
  input  logic [4:0]           motor_slot,
  input  logic [55:0]          payload,
  input  logic [BASE_ID_W-1:0] base_identifier,
  input  logic [OFFSET_W-1:0]  second_bus_offset,
  output dec_t                 dec
);

  localparam logic signed [12:0] SlotLimit = 13'(SLOT_COUNT);

  logic signed [12:0] slot_calc;
  logic signed [12:0] slot_off;
  status_t            route;
  logic               clear_ok;
  logic               frame_ok;

  always_comb begin
    slot_off  = bus_select ? $signed({8'b0, second_bus_offset}) : 13'sd0;
    slot_calc = $signed({2'b00, frame_identifier}) - $signed({2'b00, base_identifier})
                + slot_off;
    route     = routed_code(frame_identifier);
    clear_ok  = $signed({8'b0, motor_slot}) < SlotLimit;
    frame_ok  = (slot_calc >= 13'sd0) && (slot_calc < SlotLimit);
  end

  always_comb begin
    dec         = '0;
    dec.kind    = K_REPORT;
    dec.status  = ST_BAD_SLOT;
    if (mode) begin
      if (clear_ok) begin
        dec.kind   = K_CLEAR;
        dec.status = ST_CLEARED;
        dec.slot   = SLOT_IDX_W'(motor_slot);
      end
    end else if (route != ST_UPDATED) begin
      dec.status = route;
    end else if (frame_ok) begin
      dec.kind    = K_UPDATE;
      dec.status  = ST_UPDATED;
      dec.slot    = slot_calc[SLOT_IDX_W-1:0];
      dec.angle   = {payload[7:0], payload[15:8]};
      dec.speed   = {payload[23:16], payload[31:24]};
      dec.current = {payload[39:32], payload[47:40]};
      dec.temp    = payload[55:48];
    end
  end

endmodule

// ===== sv/mftt_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_state_mem
// per-slot last angle and turn count, one read and one write port
// ----------------------------------------------------------------------------
module mftt_state_mem import mftt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int AW = $clog2(SLOT_COUNT)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  state_word_t   wr_data,
  output state_word_t   rd_data
);

  state_word_t           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;
  state_word_t           rd_word;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

// ===== sv/mftt_unwrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_unwrap
// threshold wrap detection and multi-turn count update
// ----------------------------------------------------------------------------
module mftt_unwrap import mftt_pkg::*; #(
  parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
  input  logic [15:0] last_angle,
  input  logic [15:0] now_angle,
  input  logic [31:0] count,
  output logic [31:0] count_next
);

  localparam logic [31:0] Cpt = 32'(COUNTS_PER_TURN);

  logic [31:0] last32;
  logic [31:0] now32;

  always_comb begin
    last32 = {16'b0, last_angle};
    now32  = {16'b0, now_angle};
    if (last_angle > WRAP_MID && now_angle < WRAP_LOW) begin
      // forward across the zero point
      count_next = count + (Cpt - last32) + now32;
    end else if (last_angle < WRAP_MID && now_angle > WRAP_HIGH) begin
      // backward across the zero point
      count_next = count - ((Cpt - now32) + last32);
    end else begin
      count_next = count + now32 - last32;
    end
  end

endmodule

// ===== sv/motor_feedback_turn_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker_unit
// decodes motor feedback frames and tracks a multi-turn count per motor slot
// ----------------------------------------------------------------------------
// an item passes from accept into the item register, and from calc into the result register
// a new item is taken only after the current one leaves calc, set by the
//   read-modify-write of the slot state memory (read at accept, update and write back in calc)
// a result waiting in the output register holds the next item in calc, and so holds the input
// reset: synchronous active-high rst restores base_identifier = 513 and
//   second_bus_offset = 11, and marks all slots as zero, no clearing pass
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker_unit import mftt_pkg::*; #(
  parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
  parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // frame_identifier, motor_slot, byte0, byte1, byte2, byte3, byte4, byte5, byte6
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode, bus_select
  input  logic [S_TUSER_W-1:0] s_tuser,
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // slot_out, angle_raw, speed_raw, current_raw, temperature, total_count, pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // status
  output logic [M_TUSER_W-1:0] m_tuser,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_ID_W-1:0] cfg_data
);

  localparam int AW = $clog2(SLOT_COUNT);

  // configuration registers
  logic [BASE_ID_W-1:0] base_identifier;
  logic [OFFSET_W-1:0]  second_bus_offset;

  // control
  fsm_state_t state;
  fsm_state_t state_next;
  logic       in_accept;
  logic       calc_done;
  logic       mem_wr;

  // held item and datapath
  dec_t        dec;
  dec_t        item;
  state_word_t rd_data;
  state_word_t wr_data;
  logic [31:0] count_new;

  // result register
  status_t     out_status;
  logic [4:0]  out_slot;
  logic [15:0] out_angle;
  logic [15:0] out_speed;
  logic [15:0] out_current;
  logic [7:0]  out_temp;
  logic [31:0] out_total;

  // register writes are taken at any time, the block being idle by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_identifier   <= BASE_ID_RST;
      second_bus_offset <= OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_ID: base_identifier   <= cfg_data;
        REG_OFFSET:  second_bus_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // classify the incoming item
  mftt_decode #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_decode (
    .mode             (s_tuser[0]),
    .bus_select       (s_tuser[1]),
    .frame_identifier (s_tdata[10:0]),
    .motor_slot       (s_tdata[15:11]),
    .payload          (s_tdata[71:16]),
    .base_identifier  (base_identifier),
    .second_bus_offset(second_bus_offset),
    .dec              (dec)
  );

  // two-state sequencer: idle takes an item and reads its slot,
  // calc writes back updates and clears once the result register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    calc_done = 1'b0;
    case (state)
      S_IDLE:  s_tready  = 1'b1;
      S_CALC:  calc_done = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_accept = s_tvalid && s_tready;
  assign mem_wr    = calc_done && (item.kind != K_REPORT);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= dec;
    end
  end

  // slot state, read at accept and written back in calc
  mftt_state_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_state_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_accept),
    .rd_addr(dec.slot[AW-1:0]),
    .wr_en  (mem_wr),
    .wr_addr(item.slot[AW-1:0]),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  mftt_unwrap #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) u_unwrap (
    .last_angle(rd_data.angle),
    .now_angle (item.angle),
    .count     (rd_data.count),
    .count_next(count_new)
  );

  // clear keeps the last angle and zeroes the count
  always_comb begin
    if (item.kind == K_CLEAR) begin
      wr_data.angle = rd_data.angle;
      wr_data.count = '0;
    end else begin
      wr_data.angle = item.angle;
      wr_data.count = count_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (calc_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_done) begin
      out_status  <= item.status;
      out_slot    <= item.slot[4:0];
      out_angle   <= item.angle;
      out_speed   <= item.speed;
      out_current <= item.current;
      out_temp    <= item.temp;
      out_total   <= (item.kind == K_UPDATE) ? count_new : 32'd0;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_total, out_temp, out_current, out_speed, out_angle,
                    out_slot};

  // an accepted item always moves to the write-back step
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_CALC)
    else $error("accepted item did not enter calc");

  // state memory is written only while finishing an item
  a_write_in_calc: assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> (state == S_CALC) && (!m_tvalid || m_tready))
    else $error("state memory written outside write-back");

  // a finished item always shows up as a result in the next cycle
  a_done_to_valid: assert property (@(posedge clk) disable iff (rst)
    calc_done |=> m_tvalid)
    else $error("finished item produced no result");

  // a cleared slot reports a zero count
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_CLEARED) |-> m_tdata[92:61] == 32'd0)
    else $error("clear result with nonzero count");

endmodule
